>>> hdl/update_image_stream_verifier_top_assert.svh
// Assertion macros for the update image stream verifier.
`ifndef UPDATE_IMAGE_STREAM_VERIFIER_TOP_ASSERT_SVH
`define UPDATE_IMAGE_STREAM_VERIFIER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset.
`define USV_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("usv assertion failed");
// Next-cycle implication.
`define USV_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("usv assertion failed");
`else
`define USV_ASSERT_IMP(lbl, a, b)
`define USV_ASSERT_NXT(lbl, a, b)
`endif
`endif

>>> hdl/usv_pkg.sv
// Constants, status codes and beat types of the update image stream verifier.
package usv_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int PATH_BYTES = 64;
  localparam int ENTRY_LEN  = PATH_BYTES + 16;
  localparam int FIXED_HEAD = 24;
  localparam int HDR_LEN    = FIXED_HEAD + MAX_BLOCKS * ENTRY_LEN;
  localparam int SUM_START  = 8;
  localparam int SUM_OFS    = ENTRY_LEN - 4;

  localparam int OFF_W     = $clog2(HDR_LEN + 1);
  localparam int EP_W      = $clog2(ENTRY_LEN);
  localparam int BLK_IDX_W = $clog2(MAX_BLOCKS);
  localparam int BLK_CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_HDR_SUM   = 3'd2;
  localparam logic [2:0] ST_START_SCR = 3'd3;
  localparam logic [2:0] ST_END_SCR   = 3'd4;
  localparam logic [2:0] ST_BLK_SUM   = 3'd5;
  localparam logic [2:0] ST_TOO_MANY  = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  failing_block;
    logic [31:0] computed_sum;
    logic [31:0] expected_sum;
  } out_item_t;

endpackage

>>> hdl/update_image_stream_verifier_top.sv
// Update image stream verifier: header parse, section sums and one verdict per image.
//
// Takes one image byte per cycle while it parses the header and while it sums the bytes
// of a section, as long as no verdict waits untaken. Block sizes and block sums from the
// header go into two 32-entry tables with a registered read; each block pauses the input
// to fetch its table entry, each section end pauses it to judge its sum (empty sections
// chain one after another), and the byte flagged stream_end is followed by a pause that
// closes the image. The tables need no clearing: the header writes every entry before it
// is read. A verdict waits in an output register; input stalls while it waits untaken.
`include "update_image_stream_verifier_top_assert.svh"

module update_image_stream_verifier_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  usv_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output usv_pkg::out_item_t  out_data
);

  typedef enum logic [4:0] {
    PH_HDR  = 5'b00001,
    PH_SS   = 5'b00010,
    PH_ES   = 5'b00100,
    PH_BLK  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  localparam int IW = usv_pkg::BLK_IDX_W;
  localparam int CW = usv_pkg::BLK_CNT_W;
  localparam int OW = usv_pkg::OFF_W;
  localparam int EW = usv_pkg::EP_W;

  phase_t            phase_r, phase_nxt;
  logic [OW-1:0]     off_r, off_nxt;
  logic [EW-1:0]     ent_pos_r, ent_pos_nxt;
  logic [CW-1:0]     ent_idx_r, ent_idx_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [31:0]       hsum_r, hsum_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [31:0]       scr_r [0:3];
  logic [31:0]       scr_nxt [0:3];
  logic [31:0]       rsum_r, rsum_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]     blk_r, blk_nxt;
  logic              ld_r, ld_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r;
  usv_pkg::out_item_t out_data_r;

  // block tables
  logic [31:0]       size_mem [0:usv_pkg::MAX_BLOCKS-1];
  logic [31:0]       sum_mem  [0:usv_pkg::MAX_BLOCKS-1];
  logic [31:0]       size_q, sum_q;
  logic              size_we, sum_we;
  logic [IW-1:0]     rd_addr;

  logic              in_fire, can_emit, settling, emit;
  usv_pkg::out_item_t emit_data;
  logic [7:0]        b;
  logic              in_fixed, in_size, in_sum;
  logic [EW-1:0]     sum_pos;
  logic [1:0]        pos;
  logic [31:0]       word_step;
  logic [31:0]       hdr_sum;
  logic [1:0]        fld_idx;
  logic [CW-1:0]     blk_inc;

  assign can_emit  = !out_valid_r || out_ready;
  assign settling  = (phase_r == PH_SS || phase_r == PH_ES || phase_r == PH_BLK) &&
                     (ld_r || cnt_r == 32'd0);
  assign in_ready  = can_emit && !settling && !last_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = in_data.data_byte;
  assign in_fixed = off_r < OW'(usv_pkg::FIXED_HEAD);
  assign in_size  = !in_fixed && (ent_pos_r < EW'(4));
  assign in_sum   = !in_fixed && (ent_pos_r >= EW'(usv_pkg::SUM_OFS));
  assign sum_pos  = ent_pos_r - EW'(usv_pkg::SUM_OFS);
  assign pos      = in_fixed ? off_r[1:0] : (in_size ? ent_pos_r[1:0] : sum_pos[1:0]);
  assign word_step = (pos == 2'd0) ? {24'd0, b} : (word_r | ({24'd0, b} << {pos, 3'b000}));
  assign hdr_sum  = rsum_r + {24'd0, b};
  assign fld_idx  = 2'(off_r[4:2] - 3'd2);
  assign blk_inc  = blk_r + CW'(1);
  assign rd_addr  = blk_nxt[IW-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    off_nxt     = off_r;
    ent_pos_nxt = ent_pos_r;
    ent_idx_nxt = ent_idx_r;
    word_nxt    = word_r;
    hsum_nxt    = hsum_r;
    total_nxt   = total_r;
    scr_nxt     = scr_r;
    rsum_nxt    = rsum_r;
    cnt_nxt     = cnt_r;
    blk_nxt     = blk_r;
    ld_nxt      = ld_r;
    last_nxt    = last_r;
    emit        = 1'b0;
    emit_data   = '0;
    size_we     = 1'b0;
    sum_we      = 1'b0;

    if (last_r && !settling && can_emit) begin
      // close the image: report truncation if nothing was judged, then rearm
      if (phase_r != PH_DONE) begin
        emit = 1'b1;
        emit_data.status       = usv_pkg::ST_TRUNC;
        emit_data.computed_sum = rsum_r;
        case (phase_r)
          PH_HDR:  emit_data.expected_sum = hsum_r;
          PH_SS:   emit_data.expected_sum = scr_r[1];
          PH_ES:   emit_data.expected_sum = scr_r[3];
          PH_BLK:  emit_data.expected_sum = sum_q;
          default: emit_data.expected_sum = 32'd0;
        endcase
      end
      phase_nxt   = PH_HDR;
      off_nxt     = '0;
      ent_pos_nxt = '0;
      ent_idx_nxt = '0;
      word_nxt    = '0;
      hsum_nxt    = '0;
      total_nxt   = '0;
      for (int i = 0; i < 4; i++) scr_nxt[i] = '0;
      rsum_nxt    = '0;
      cnt_nxt     = '0;
      blk_nxt     = '0;
      ld_nxt      = 1'b0;
      last_nxt    = 1'b0;
    end else if (settling && can_emit) begin
      case (phase_r)
        PH_SS: begin
          if (rsum_r != scr_r[1]) begin
            emit = 1'b1;
            emit_data.status       = usv_pkg::ST_START_SCR;
            emit_data.computed_sum = rsum_r;
            emit_data.expected_sum = scr_r[1];
            phase_nxt = PH_DONE;
          end else begin
            rsum_nxt  = '0;
            phase_nxt = PH_ES;
            cnt_nxt   = scr_r[2];
          end
        end
        PH_ES: begin
          if (rsum_r != scr_r[3]) begin
            emit = 1'b1;
            emit_data.status       = usv_pkg::ST_END_SCR;
            emit_data.computed_sum = rsum_r;
            emit_data.expected_sum = scr_r[3];
            phase_nxt = PH_DONE;
          end else begin
            rsum_nxt  = '0;
            blk_nxt   = '0;
            if (total_r == 32'd0) begin
              emit = 1'b1;
              emit_data.status = usv_pkg::ST_OK;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_BLK;
              ld_nxt    = 1'b1;
            end
          end
        end
        PH_BLK: begin
          if (ld_r) begin
            cnt_nxt = size_q;
            ld_nxt  = 1'b0;
          end else if (rsum_r != sum_q) begin
            emit = 1'b1;
            emit_data.status        = usv_pkg::ST_BLK_SUM;
            emit_data.failing_block = 5'(blk_r);
            emit_data.computed_sum  = rsum_r;
            emit_data.expected_sum  = sum_q;
            phase_nxt = PH_DONE;
          end else begin
            rsum_nxt = '0;
            blk_nxt  = blk_inc;
            if (32'(blk_inc) >= total_r) begin
              emit = 1'b1;
              emit_data.status = usv_pkg::ST_OK;
              phase_nxt = PH_DONE;
            end else begin
              ld_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (in_fire) begin
      last_nxt = in_data.stream_end;
      case (phase_r)
        PH_HDR: begin
          if (off_r >= OW'(usv_pkg::SUM_START)) rsum_nxt = hdr_sum;
          if (in_fixed || in_size || in_sum) word_nxt = word_step;
          if (in_fixed) begin
            case (off_r[4:2])
              3'd0:    hsum_nxt = word_step;
              3'd1:    total_nxt = word_step;
              default: scr_nxt[fld_idx] = word_step;
            endcase
          end else begin
            size_we = in_size && (pos == 2'd3);
            sum_we  = in_sum && (pos == 2'd3);
            if (ent_pos_r == EW'(usv_pkg::ENTRY_LEN - 1)) begin
              ent_pos_nxt = '0;
              ent_idx_nxt = ent_idx_r + CW'(1);
            end else begin
              ent_pos_nxt = ent_pos_r + EW'(1);
            end
          end
          off_nxt = off_r + OW'(1);
          if (off_r == OW'(usv_pkg::HDR_LEN - 1)) begin
            if (hdr_sum != hsum_r) begin
              emit = 1'b1;
              emit_data.status       = usv_pkg::ST_HDR_SUM;
              emit_data.computed_sum = hdr_sum;
              emit_data.expected_sum = hsum_r;
              phase_nxt = PH_DONE;
            end else if (total_r > 32'(usv_pkg::MAX_BLOCKS)) begin
              emit = 1'b1;
              emit_data.status       = usv_pkg::ST_TOO_MANY;
              emit_data.computed_sum = total_r;
              emit_data.expected_sum = 32'(usv_pkg::MAX_BLOCKS);
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_SS;
              rsum_nxt  = '0;
              cnt_nxt   = scr_r[0];
            end
          end
        end
        PH_SS, PH_ES, PH_BLK: begin
          rsum_nxt = rsum_r + {24'd0, b};
          cnt_nxt  = cnt_r - 32'd1;
        end
        default: ; // drop bytes after the verdict
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR;
      off_r     <= '0;
      ent_pos_r <= '0;
      ent_idx_r <= '0;
      word_r    <= '0;
      hsum_r    <= '0;
      total_r   <= '0;
      for (int i = 0; i < 4; i++) scr_r[i] <= '0;
      rsum_r    <= '0;
      cnt_r     <= '0;
      blk_r     <= '0;
      ld_r      <= 1'b0;
      last_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      off_r     <= off_nxt;
      ent_pos_r <= ent_pos_nxt;
      ent_idx_r <= ent_idx_nxt;
      word_r    <= word_nxt;
      hsum_r    <= hsum_nxt;
      total_r   <= total_nxt;
      scr_r     <= scr_nxt;
      rsum_r    <= rsum_nxt;
      cnt_r     <= cnt_nxt;
      blk_r     <= blk_nxt;
      ld_r      <= ld_nxt;
      last_r    <= last_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  // table write on the last byte of a word, registered read of the next block
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[ent_idx_r[IW-1:0]] <= word_step;
    end
    if (sum_we) begin
      sum_mem[ent_idx_r[IW-1:0]] <= word_step;
    end
    size_q <= size_mem[rd_addr];
    sum_q  <= sum_mem[rd_addr];
  end

  `USV_ASSERT_IMP(a_ld_in_blk, ld_r, phase_r == PH_BLK)
  `USV_ASSERT_IMP(a_blk_in_range, phase_r == PH_BLK, 32'(blk_r) < total_r)
  `USV_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_ready, !emit)
  `USV_ASSERT_NXT(a_emit_ends, emit, phase_r == PH_DONE || phase_r == PH_HDR)

endmodule

>>> tb/update_image_stream_verifier_top_tb.sv
// Self-checking testbench for the update image stream verifier: image stimulus, verdict checks.
module update_image_stream_verifier_top_tb;

  localparam int RAND_BEATS   = 1250;
  localparam int RAND_IMAGES  = 48;
  localparam int LONG_SECTION = 256;
  localparam int CLOSE_CYCLES = 100;

  typedef enum logic [2:0] {SEC_HEADER, SEC_START, SEC_END, SEC_BLOCKS} section_e;
  typedef enum logic [1:0] {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;
  typedef enum int {FLAW_NONE, FLAW_HDR_SUM, FLAW_START, FLAW_END, FLAW_BLK} flaw_e;

  typedef struct {
    logic [31:0] blocks;       // block count stored in the header
    logic [31:0] start_len;
    logic [31:0] end_len;
    logic [31:0] blk_len_max;  // block sizes drawn from 0 up to this
    flaw_e       flaw;
    int unsigned flaw_blk;
    int          cut_at;       // index of the last byte sent, -1 for the whole image
    int unsigned tail;         // bytes appended after the image
  } image_plan_t;

  typedef struct {
    logic [7:0]         b;
    logic               last;
    bit                 has_verdict;
    usv_pkg::out_item_t verdict;
  } raw_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  usv_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  usv_pkg::out_item_t out_data;

  update_image_stream_verifier_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  initial begin
    #100_000_000;
    $display("update_image_stream_verifier_top verification failed");
    $finish;
  end

  // Image tracker state
  section_e                      sec;
  logic [usv_pkg::OFF_W-1:0]     hdr_pos;
  logic [31:0]                   word_acc;
  logic [31:0]                   hdr_sum_want;
  logic [31:0]                   blk_cnt;
  logic [31:0]                   scr_info [4];
  logic [31:0]                   size_tab [usv_pkg::MAX_BLOCKS];
  logic [31:0]                   sum_tab [usv_pkg::MAX_BLOCKS];
  logic [31:0]                   run_sum;
  logic [31:0]                   bytes_left;
  logic [usv_pkg::BLK_CNT_W-1:0] blk_idx;
  bit                            judged;

  usv_pkg::out_item_t pending_verdicts [$];
  logic [7:0]         img_q [$];
  pace_e              pace = PACE_FULL;
  bit                 typed_ok;
  usv_pkg::out_item_t typed_item;
  int                 errors;
  int                 img_no;
  int                 random_beats;
  int                 random_images;

  function automatic void rearm_image();
    sec = SEC_HEADER;
    hdr_pos = '0;
    word_acc = '0;
    hdr_sum_want = '0;
    blk_cnt = '0;
    foreach (scr_info[i]) scr_info[i] = '0;
    foreach (size_tab[i]) size_tab[i] = '0;
    foreach (sum_tab[i]) sum_tab[i] = '0;
    run_sum = '0;
    bytes_left = '0;
    blk_idx = '0;
    judged = 1'b0;
  endfunction

  function automatic void give_verdict(output usv_pkg::out_item_t r, input logic [2:0] st,
                                       input logic [4:0] blk, input logic [31:0] got,
                                       input logic [31:0] want);
    r = '{status: st, failing_block: blk, computed_sum: got, expected_sum: want};
    judged = 1'b1;
  endfunction

  function automatic logic [31:0] merge_lane(int unsigned lane, logic [7:0] b);
    if (lane == 0) word_acc = {24'd0, b};
    else word_acc |= {24'd0, b} << (8 * lane);
    return word_acc;
  endfunction

  function automatic void take_header_byte(int unsigned pos, logic [7:0] b);
    int unsigned rel;
    int unsigned k;
    int unsigned r;
    if (pos < usv_pkg::FIXED_HEAD) begin
      case (pos / 4)
        0: hdr_sum_want = merge_lane(pos % 4, b);
        1: blk_cnt = merge_lane(pos % 4, b);
        default: scr_info[pos / 4 - 2] = merge_lane(pos % 4, b);
      endcase
    end else begin
      rel = pos - usv_pkg::FIXED_HEAD;
      k = rel / usv_pkg::ENTRY_LEN;
      r = rel % usv_pkg::ENTRY_LEN;
      // path, destination size and option bytes are not kept
      if (r < 4) size_tab[k] = merge_lane(r, b);
      else if (r >= usv_pkg::SUM_OFS) sum_tab[k] = merge_lane(r - usv_pkg::SUM_OFS, b);
    end
  endfunction

  // Judge every section that has run out of bytes, empty ones included.
  function automatic bit judge_pending(output usv_pkg::out_item_t r);
    logic [31:0] want;
    while (1'b1) begin
      if (sec == SEC_START || sec == SEC_END) begin
        want = (sec == SEC_START) ? scr_info[1] : scr_info[3];
        if (bytes_left != 0) return 1'b0;
        if (run_sum != want) begin
          give_verdict(r, (sec == SEC_START) ? usv_pkg::ST_START_SCR : usv_pkg::ST_END_SCR,
                       5'd0, run_sum, want);
          return 1'b1;
        end
        run_sum = '0;
        if (sec == SEC_START) begin
          sec = SEC_END;
          bytes_left = scr_info[2];
        end else begin
          sec = SEC_BLOCKS;
          blk_idx = '0;
          if (blk_cnt > 0) bytes_left = size_tab[0];
        end
      end else if (sec == SEC_BLOCKS) begin
        if (blk_idx >= blk_cnt || blk_idx >= usv_pkg::MAX_BLOCKS) begin
          give_verdict(r, usv_pkg::ST_OK, 5'd0, 32'd0, 32'd0);
          return 1'b1;
        end
        if (bytes_left != 0) return 1'b0;
        if (run_sum != sum_tab[blk_idx]) begin
          give_verdict(r, usv_pkg::ST_BLK_SUM, blk_idx[4:0], run_sum, sum_tab[blk_idx]);
          return 1'b1;
        end
        run_sum = '0;
        blk_idx = blk_idx + 1'b1;
        if (blk_idx < blk_cnt && blk_idx < usv_pkg::MAX_BLOCKS) bytes_left = size_tab[blk_idx];
      end else begin
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit track_byte(input usv_pkg::in_item_t it,
                                    output usv_pkg::out_item_t r);
    bit          hit;
    logic [31:0] want;
    hit = 1'b0;
    if (!judged) begin
      if (sec == SEC_HEADER) begin
        if (hdr_pos >= usv_pkg::SUM_START) run_sum += {24'd0, it.data_byte};
        take_header_byte(hdr_pos, it.data_byte);
        hdr_pos = hdr_pos + 1'b1;
        if (hdr_pos >= usv_pkg::HDR_LEN) begin
          if (run_sum != hdr_sum_want) begin
            give_verdict(r, usv_pkg::ST_HDR_SUM, 5'd0, run_sum, hdr_sum_want);
            hit = 1'b1;
          end else if (blk_cnt > usv_pkg::MAX_BLOCKS) begin
            give_verdict(r, usv_pkg::ST_TOO_MANY, 5'd0, blk_cnt, 32'(usv_pkg::MAX_BLOCKS));
            hit = 1'b1;
          end else begin
            sec = SEC_START;
            run_sum = '0;
            bytes_left = scr_info[0];
            hit = judge_pending(r);
          end
        end
      end else begin
        run_sum += {24'd0, it.data_byte};
        bytes_left = bytes_left - 1;
        hit = judge_pending(r);
      end
    end
    if (it.stream_end) begin
      if (!judged) begin
        case (sec)
          SEC_HEADER: want = hdr_sum_want;
          SEC_START:  want = scr_info[1];
          SEC_END:    want = scr_info[3];
          default:    want = (blk_idx < usv_pkg::MAX_BLOCKS) ? sum_tab[blk_idx] : 32'd0;
        endcase
        give_verdict(r, usv_pkg::ST_TRUNC, 5'd0, run_sum, want);
        hit = 1'b1;
      end
      rearm_image();
    end
    return hit;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    usv_pkg::out_item_t calc;
    usv_pkg::out_item_t seen;
    bit                 hit;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        hit = track_byte(in_data, calc);
        if (typed_ok) pending_verdicts.push_back(typed_item);
        else if (hit) pending_verdicts.push_back(calc);
      end
      if (out_valid && out_ready) begin
        seen = out_data;
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual %h", $time, seen);
          errors++;
        end else begin
          calc = pending_verdicts.pop_front();
          check_field("status", 32'(calc.status), 32'(seen.status));
          check_field("failing_block", 32'(calc.failing_block), 32'(seen.failing_block));
          check_field("computed_sum", calc.computed_sum, seen.computed_sum);
          check_field("expected_sum", calc.expected_sum, seen.expected_sum);
        end
      end
    end
  end

  always @(negedge clk) begin
    case (pace)
      PACE_SNK_STALL: out_ready <= ($urandom_range(99) >= 85);
      PACE_BOTH:      out_ready <= ($urandom_range(99) >= 35);
      default:        out_ready <= 1'b1;
    endcase
  end

  function automatic bit src_gap();
    case (pace)
      PACE_SRC_IDLE: return $urandom_range(99) < 85;
      PACE_BOTH:     return $urandom_range(99) < 35;
      default:       return 1'b0;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(logic [7:0] b, logic last, bit typed,
                           usv_pkg::out_item_t typed_v);
    while (src_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_ok = typed;
    typed_item = typed_v;
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, stream_end: last};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic run_image();
    img_no++;
    pace = pace_e'(img_no % 4);
    // hold off now and then until every verdict has drained
    if (img_no % 7 == 0) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (pending_verdicts.size() != 0);
    end
    for (int i = 0; i < img_q.size(); i++)
      send_beat(img_q[i], i == img_q.size() - 1, 1'b0, '0);
  endtask

  function automatic void put_word(int unsigned off, logic [31:0] w);
    for (int i = 0; i < 4; i++) img_q[off + i] = w[8*i +: 8];
  endfunction

  // Append a section body; a very long one gets a few bytes and ends the image there.
  function automatic logic [31:0] add_section(logic [31:0] len, ref bit stop);
    logic [31:0] acc;
    logic [7:0]  b;
    int unsigned n;
    acc = '0;
    if (stop) return $urandom;
    n = (len > LONG_SECTION) ? 12 : len;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      img_q.push_back(b);
      acc += {24'd0, b};
    end
    if (len > LONG_SECTION) stop = 1'b1;
    return acc;
  endfunction

  function automatic void build_image(image_plan_t p);
    logic [31:0] flip;
    logic [31:0] hsum;
    logic [31:0] start_sum;
    logic [31:0] end_sum;
    logic [31:0] len;
    logic [31:0] sum;
    int unsigned nb;
    bit          stop;
    flip = 32'd1 << $urandom_range(31);
    stop = 1'b0;
    img_q.delete();
    for (int i = 0; i < usv_pkg::HDR_LEN; i++) img_q.push_back(8'($urandom));
    nb = (p.blocks > usv_pkg::MAX_BLOCKS) ? usv_pkg::MAX_BLOCKS : p.blocks;
    put_word(4, p.blocks);
    start_sum = add_section(p.start_len, stop);
    end_sum = add_section(p.end_len, stop);
    put_word(8, p.start_len);
    put_word(12, start_sum ^ ((p.flaw == FLAW_START) ? flip : 32'd0));
    put_word(16, p.end_len);
    put_word(20, end_sum ^ ((p.flaw == FLAW_END) ? flip : 32'd0));
    for (int k = 0; k < nb; k++) begin
      len = $urandom_range(p.blk_len_max, 0);
      sum = add_section(len, stop);
      if (p.flaw == FLAW_BLK && k == p.flaw_blk) sum ^= flip;
      put_word(usv_pkg::FIXED_HEAD + k * usv_pkg::ENTRY_LEN, len);
      put_word(usv_pkg::FIXED_HEAD + k * usv_pkg::ENTRY_LEN + usv_pkg::SUM_OFS, sum);
    end
    hsum = '0;
    for (int i = usv_pkg::SUM_START; i < usv_pkg::HDR_LEN; i++) hsum += {24'd0, img_q[i]};
    put_word(0, hsum ^ ((p.flaw == FLAW_HDR_SUM) ? flip : 32'd0));
    if (p.cut_at >= 0) begin
      while (img_q.size() > p.cut_at + 1) void'(img_q.pop_back());
    end else begin
      repeat (p.tail) img_q.push_back(8'($urandom));
    end
  endfunction

  function automatic logic [31:0] pick_script_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 32'd0;
    if (r < 19) return $urandom;
    return $urandom_range(24);
  endfunction

  function automatic image_plan_t random_plan();
    image_plan_t p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) p.blocks = $urandom_range(8);
    else if (pick < 80) p.blocks = usv_pkg::MAX_BLOCKS;
    else if (pick < 90) p.blocks = $urandom_range(usv_pkg::MAX_BLOCKS - 1, 9);
    else if (pick < 95) p.blocks = usv_pkg::MAX_BLOCKS + 1;
    else p.blocks = $urandom;
    p.start_len = pick_script_len();
    p.end_len = pick_script_len();
    p.blk_len_max = ($urandom_range(99) < 4) ? 32'hFFFF_FFFF : $urandom_range(16);
    pick = $urandom_range(7);
    p.flaw = (pick < 4) ? FLAW_NONE : flaw_e'(pick - 3);
    p.flaw_blk = $urandom_range(usv_pkg::MAX_BLOCKS - 1);
    p.cut_at = ($urandom_range(99) < 12) ? int'($urandom_range(usv_pkg::HDR_LEN + 60)) : -1;
    p.tail = $urandom_range(3);
    return p;
  endfunction

  // Single-byte and short images right after reset, verdicts read off by hand.
  raw_row_t raw_tab [17] = '{
    '{8'h00, 1'b1, 1'b1, '{usv_pkg::ST_TRUNC, 5'd0, 32'd0, 32'h0000_0000}},
    '{8'hFF, 1'b1, 1'b1, '{usv_pkg::ST_TRUNC, 5'd0, 32'd0, 32'h0000_00FF}},
    '{8'h80, 1'b1, 1'b1, '{usv_pkg::ST_TRUNC, 5'd0, 32'd0, 32'h0000_0080}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{usv_pkg::ST_TRUNC, 5'd0, 32'd0, 32'hFFFF_FFFF}},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0},
    '{8'h78, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{usv_pkg::ST_TRUNC, 5'd0, 32'h0000_01FE, 32'h7856_3412}}
  };

  image_plan_t scenario_tab [15] = '{
    // every section empty: verdict on the last header byte
    '{32'd0, 32'd0, 32'd0, 32'd0, FLAW_NONE, 0, -1, 0},
    // trailing bytes after the verdict
    '{32'd0, 32'd0, 32'd0, 32'd0, FLAW_NONE, 0, -1, 3},
    '{32'd3, 32'd5, 32'd7, 32'd4, FLAW_NONE, 0, -1, 1},
    '{32'd32, 32'd2, 32'd2, 32'd3, FLAW_NONE, 0, -1, 0},
    '{32'd2, 32'd3, 32'd3, 32'd3, FLAW_HDR_SUM, 0, -1, 0},
    '{32'd2, 32'd4, 32'd3, 32'd3, FLAW_START, 0, -1, 0},
    '{32'd2, 32'd0, 32'd0, 32'd3, FLAW_END, 0, -1, 0},
    '{32'd4, 32'd1, 32'd1, 32'd5, FLAW_BLK, 0, -1, 0},
    '{32'd32, 32'd0, 32'd0, 32'd2, FLAW_BLK, 31, -1, 2},
    '{32'd33, 32'd1, 32'd1, 32'd1, FLAW_NONE, 0, -1, 0},
    '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, FLAW_NONE, 0, -1, 0},
    '{32'd2, 32'd4, 32'd4, 32'd4, FLAW_NONE, 0, 1000, 0},
    '{32'd2, 32'd6, 32'd6, 32'd6, FLAW_NONE, 0, usv_pkg::HDR_LEN + 8, 0},
    '{32'd5, 32'd0, 32'd0, 32'd8, FLAW_NONE, 0, usv_pkg::HDR_LEN + 10, 0},
    '{32'd1, 32'h8000_0000, 32'd0, 32'd0, FLAW_NONE, 0, -1, 0}
  };

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    typed_ok = 1'b0;
    typed_item = '0;
    rearm_image();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pace = PACE_BOTH;
    foreach (raw_tab[i])
      send_beat(raw_tab[i].b, raw_tab[i].last, raw_tab[i].has_verdict, raw_tab[i].verdict);
    foreach (scenario_tab[i]) begin
      build_image(scenario_tab[i]);
      run_image();
    end

    while (random_beats < RAND_BEATS || random_images < RAND_IMAGES) begin
      if ($urandom_range(99) < 30) begin
        // short random image, cut off inside the header
        img_q.delete();
        n = ($urandom_range(9) == 0) ? $urandom_range(usv_pkg::HDR_LEN - 1, 1)
                                     : $urandom_range(40, 1);
        repeat (n) img_q.push_back(8'($urandom));
      end else begin
        build_image(random_plan());
      end
      random_beats += img_q.size();
      random_images++;
      run_image();
    end

    in_valid <= 1'b0;
    pace = PACE_FULL;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (CLOSE_CYCLES) @(posedge clk);
    if (errors == 0) $display("update_image_stream_verifier_top verification clean");
    else $display("update_image_stream_verifier_top verification failed");
    $finish;
  end

endmodule
